// ===== rtl/dipa_pkg.sv =====
// Shared types and constants for the dotted IPv4 address parser.
// Used by dipa_char_class and dotted_ipv4_address_parser; no dependencies.
`default_nettype none

package dipa_pkg;

    // Number base of the part being read.
    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;

    // Position inside the part being read.
    localparam logic [1:0] PHASE_START  = 2'd0;
    localparam logic [1:0] PHASE_ZERO   = 2'd1;
    localparam logic [1:0] PHASE_DIGITS = 2'd2;

    localparam int MAX_PARTS = 4;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_X  = 8'h78;

    // Classification of one character.
    typedef struct packed {
        logic       is_dec;
        logic       is_hex_letter;
        logic [3:0] nibble;
        logic       is_zero;
        logic       is_x;
        logic       is_dot;
        logic       is_blank;
    } dipa_class_t;

endpackage

`default_nettype wire

// ===== rtl/dipa_char_class.sv =====
// Character classifier for the dotted IPv4 address parser.
// Depends on dipa_pkg for the character codes and the class struct.
`default_nettype none

module dipa_char_class (
    input  wire logic [7:0]          char_code,
    output dipa_pkg::dipa_class_t    char_class
);
    import dipa_pkg::*;

    logic is_dec;
    logic is_letter;

    assign is_dec    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign is_letter = ((char_code >= CH_LC_A) && (char_code <= CH_LC_F))
                    || ((char_code >= CH_UC_A) && (char_code <= CH_UC_F));

    always_comb
    begin
        char_class.is_dec        = is_dec;
        char_class.is_hex_letter = is_letter;
        // Letters a-f and A-F carry 1..6 in the low nibble.
        char_class.nibble        = is_dec ? char_code[3:0] : char_code[3:0] + 4'd9;
        char_class.is_zero       = (char_code == CH_ZERO);
        char_class.is_x          = (char_code == CH_LC_X) || (char_code == CH_UC_X);
        char_class.is_dot        = (char_code == CH_DOT);
        char_class.is_blank      = (char_code == CH_NUL) || (char_code == CH_SPACE)
                                || ((char_code >= CH_TAB) && (char_code <= CH_CR));
    end

endmodule

`default_nettype wire

// ===== rtl/dotted_ipv4_address_parser.sv =====
// Top level of the dotted IPv4 address parser: input register, parse state
// and result register. Depends on dipa_pkg and dipa_char_class.
//
// The block takes one text character per word and parses a dotted IPv4
// address of up to four parts in C number syntax (decimal, octal after a
// leading zero, hex after x or X), returning the host-order address with a
// bad_format flag. A word with tuser high starts a new string. It accepts one
// character every cycle while the result register is empty or being read; an
// unread result word stalls the input. The character that ends the string is held
// in the input register, and the result word is registered when it advances. The
// input rate is set by the accumulator update (multiply by the base and add the
// digit), which is combinational. Only the character that ends a parse, or a
// fourth dot, produces a result word.
`default_nettype none

module dotted_ipv4_address_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] char_code
    input  wire logic        s_tuser,    // [0] new_string
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,    // [31:0] address
    output logic             m_tuser     // [0] bad_format
);
    import dipa_pkg::*;

    // Input stage.
    logic        in_valid_reg;
    logic [7:0]  char_reg;
    logic        new_string_reg;
    logic        advance;

    // Parse state.
    logic [31:0] acc_reg, acc_next;
    logic [1:0]  base_reg, base_next;
    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  parts_reg, parts_next;
    logic        busy_reg, busy_next;
    logic [7:0]  part_bytes_reg [MAX_PARTS-1];

    dipa_class_t cls;
    logic        done;
    logic        part_wr;
    logic [1:0]  part_idx;
    logic [7:0]  part_byte;
    logic        res_valid;
    logic        res_bad;
    logic [31:0] res_addr;

    dipa_char_class u_char_class (
        .char_code  (char_reg),
        .char_class (cls)
    );

    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            char_reg       <= s_tdata;
            new_string_reg <= s_tuser;
        end
    end

    always_comb
    begin
        acc_next   = acc_reg;
        base_next  = base_reg;
        phase_next = phase_reg;
        parts_next = parts_reg;
        busy_next  = busy_reg;
        part_wr    = 1'b0;
        part_idx   = parts_reg;
        part_byte  = acc_reg[7:0];
        res_valid  = 1'b0;
        res_bad    = 1'b0;
        res_addr   = 32'd0;

        if (new_string_reg)
        begin
            acc_next   = 32'd0;
            base_next  = BASE_DEC;
            phase_next = PHASE_START;
            parts_next = 2'd0;
            busy_next  = 1'b1;
        end
        done = !busy_next;

        if (!done && phase_next == PHASE_START)
        begin
            if (cls.is_zero)
            begin
                base_next  = BASE_OCT;
                phase_next = PHASE_ZERO;
                done       = 1'b1;
            end
            else
            begin
                phase_next = PHASE_ZERO;
            end
        end

        // A hex prefix is taken with or without a leading zero.
        if (!done && phase_next == PHASE_ZERO)
        begin
            phase_next = PHASE_DIGITS;
            if (cls.is_x)
            begin
                base_next = BASE_HEX;
                done      = 1'b1;
            end
        end

        if (!done)
        begin
            if (cls.is_dec || (base_next == BASE_HEX && cls.is_hex_letter))
            begin
                case (base_next)
                    BASE_HEX: acc_next = (acc_next << 4) + {28'd0, cls.nibble};
                    BASE_OCT: acc_next = (acc_next << 3) + {28'd0, cls.nibble};
                    default:  acc_next = (acc_next << 3) + (acc_next << 1)
                                       + {28'd0, cls.nibble};
                endcase
            end
            else if (cls.is_dot)
            begin
                if (parts_next < 2'(MAX_PARTS - 1))
                begin
                    part_wr    = 1'b1;
                    part_idx   = parts_next;
                    part_byte  = acc_next[7:0];
                    parts_next = parts_next + 2'd1;
                    acc_next   = 32'd0;
                    base_next  = BASE_DEC;
                    phase_next = PHASE_START;
                end
                else
                begin
                    res_valid = 1'b1;
                    res_bad   = 1'b1;
                    busy_next = 1'b0;
                end
            end
            else
            begin
                busy_next = 1'b0;
                res_valid = 1'b1;
                if (cls.is_blank)
                begin
                    case (parts_next)
                        2'd0: res_addr = acc_next;
                        2'd1: res_addr = {part_bytes_reg[0], acc_next[23:0]};
                        2'd2: res_addr = {part_bytes_reg[0], part_bytes_reg[1],
                                          acc_next[15:0]};
                        default: res_addr = {part_bytes_reg[0], part_bytes_reg[1],
                                             part_bytes_reg[2], acc_next[7:0]};
                    endcase
                end
                else
                begin
                    res_bad = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= 32'd0;
            base_reg  <= BASE_DEC;
            phase_reg <= PHASE_START;
            parts_reg <= 2'd0;
            busy_reg  <= 1'b0;
        end
        else if (advance)
        begin
            acc_reg   <= acc_next;
            base_reg  <= base_next;
            phase_reg <= phase_next;
            parts_reg <= parts_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && part_wr)
        begin
            part_bytes_reg[part_idx] <= part_byte;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid <= 1'b0;
        end
        else if (advance && res_valid)
        begin
            m_tvalid <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            m_tdata <= res_addr;
            m_tuser <= res_bad;
        end
    end

    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 32'd0)
        else $error("error result carries a nonzero address");

    a_result_ends_string: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid |=> !busy_reg)
        else $error("parse still busy after a result");

    a_idle_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !new_string_reg && !busy_reg |-> !res_valid)
        else $error("result produced while waiting for a new string");

    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && m_tvalid && !m_tready)
        else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

// ===== test/tb_dotted_ipv4_address_parser.sv =====
// Self-checking testbench for dotted_ipv4_address_parser: a directed table, then random
// address text, each accepted character predicted by an in-bench parser and compared.
// Depends on dipa_pkg and the parser RTL only.
`timescale 1ns / 100ps

module tb_dotted_ipv4_address_parser;

    import dipa_pkg::*;

    localparam int        IDLE_LIMIT = 2000;
    localparam int        CHAR_TARGET = 950;
    localparam logic [7:0] CH_VT = 8'h0b;

    typedef struct packed {
        logic [7:0]  ch;
        logic        fresh;
        logic        typed;
        logic [31:0] addr;
        logic        bad;
    } probe_t;

    typedef struct {
        logic [31:0] addr;
        logic        bad;
    } verdict_t;

    // Directed characters. Rows with typed set carry the result they must end with.
    localparam probe_t PROBES [26] = '{
        '{"A",      1'b0, 1'b0, 32'h0,        1'b0},   // ignored, no string open yet
        '{CH_NUL,   1'b1, 1'b1, 32'h0,        1'b0},   // empty string parses as 0
        '{"q",      1'b0, 1'b0, 32'h0,        1'b0},   // ignored after a result
        '{CH_DOT,   1'b1, 1'b0, 32'h0,        1'b0},
        '{CH_DOT,   1'b0, 1'b0, 32'h0,        1'b0},
        '{CH_DOT,   1'b0, 1'b0, 32'h0,        1'b0},
        '{CH_DOT,   1'b0, 1'b1, 32'h0,        1'b1},   // a fourth dot fails at once
        '{8'hff,    1'b1, 1'b1, 32'h0,        1'b1},   // high bytes are never digits
        '{"5",      1'b1, 1'b0, 32'h0,        1'b0},
        '{CH_ZERO,  1'b1, 1'b0, 32'h0,        1'b0},   // restart drops the 5
        '{CH_UC_X,  1'b0, 1'b0, 32'h0,        1'b0},
        '{"f",      1'b0, 1'b0, 32'h0,        1'b0},
        '{"F",      1'b0, 1'b0, 32'h0,        1'b0},
        '{CH_TAB,   1'b0, 1'b1, 32'h0000_00ff, 1'b0},
        '{CH_ZERO,  1'b1, 1'b0, 32'h0,        1'b0},
        '{CH_NINE,  1'b0, 1'b0, 32'h0,        1'b0},   // 9 still taken in octal
        '{CH_SPACE, 1'b0, 1'b0, 32'h0,        1'b0},
        '{CH_LC_X,  1'b1, 1'b0, 32'h0,        1'b0},   // hex without a leading zero
        '{"1",      1'b0, 1'b0, 32'h0,        1'b0},
        '{CH_CR,    1'b0, 1'b0, 32'h0,        1'b0},
        '{"7",      1'b1, 1'b0, 32'h0,        1'b0},
        '{"z",      1'b0, 1'b1, 32'h0,        1'b1},
        '{"1",      1'b1, 1'b0, 32'h0,        1'b0},
        '{CH_DOT,   1'b0, 1'b0, 32'h0,        1'b0},
        '{"2",      1'b0, 1'b0, 32'h0,        1'b0},
        '{CH_VT,    1'b0, 1'b0, 32'h0,        1'b0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;      // [7:0] char_code
    logic        s_tuser = 1'b0;       // [0] new_string
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [31:0] m_tdata;              // [31:0] address
    logic        m_tuser;              // [0] bad_format

    // Parser state of the predictor.
    logic [31:0] acc_value = '0;
    logic [1:0]  radix = BASE_DEC;
    logic [1:0]  part_pos = PHASE_START;
    logic [1:0]  closed_parts = '0;
    logic [31:0] closed_value [3] = '{default: '0};
    logic        in_string = 1'b0;

    verdict_t    pending_verdicts [$];
    int          mismatches = 0;
    int          sent_chars = 0;
    int          idle_cycles = 0;
    int          gap_pct = 20;
    bit          quiet = 1'b0;

    dotted_ipv4_address_parser i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic logic [31:0] packed_address();
        case (closed_parts)
            2'd0:    return acc_value;
            2'd1:    return {closed_value[0][7:0], acc_value[23:0]};
            2'd2:    return {closed_value[0][7:0], closed_value[1][7:0], acc_value[15:0]};
            default: return {closed_value[0][7:0], closed_value[1][7:0],
                             closed_value[2][7:0], acc_value[7:0]};
        endcase
    endfunction

    // Advances the predictor by one character; returns 1 when it ends the string.
    function automatic bit parse_char(input logic [7:0] c, input logic fresh,
                                      output logic [31:0] addr, output logic bad);
        logic [7:0] ofs;
        logic [4:0] dv;
        addr = '0;
        bad = 1'b0;
        if (fresh)
        begin
            acc_value = '0;
            radix = BASE_DEC;
            part_pos = PHASE_START;
            closed_parts = '0;
            in_string = 1'b1;
        end
        if (!in_string)
            return 1'b0;
        if (part_pos == PHASE_START)
        begin
            part_pos = PHASE_ZERO;
            if (c == CH_ZERO)
            begin
                radix = BASE_OCT;
                return 1'b0;
            end
        end
        if (part_pos == PHASE_ZERO)
        begin
            part_pos = PHASE_DIGITS;
            if (c == CH_LC_X || c == CH_UC_X)
            begin
                radix = BASE_HEX;
                return 1'b0;
            end
        end

        dv = 5'd16;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            ofs = c - CH_ZERO;
            dv = ofs[4:0];
        end
        else if (radix == BASE_HEX && c >= CH_LC_A && c <= CH_LC_F)
        begin
            ofs = c - CH_LC_A + 8'd10;
            dv = ofs[4:0];
        end
        else if (radix == BASE_HEX && c >= CH_UC_A && c <= CH_UC_F)
        begin
            ofs = c - CH_UC_A + 8'd10;
            dv = ofs[4:0];
        end

        if (dv != 5'd16)
        begin
            if (radix == BASE_HEX)
                acc_value = (acc_value << 4) + {27'd0, dv};
            else if (radix == BASE_OCT)
                acc_value = (acc_value << 3) + {27'd0, dv};
            else
                acc_value = acc_value * 32'd10 + {27'd0, dv};
            return 1'b0;
        end

        if (c == CH_DOT && closed_parts != 2'd3)
        begin
            closed_value[closed_parts] = acc_value;
            closed_parts++;
            acc_value = '0;
            radix = BASE_DEC;
            part_pos = PHASE_START;
            return 1'b0;
        end

        in_string = 1'b0;
        if (c != CH_DOT && (c == CH_NUL || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)))
            addr = packed_address();
        else
            bad = 1'b1;
        return 1'b1;
    endfunction

    // Drives one character, waits for it to be taken and records what it must produce.
    task automatic send_char(input logic [7:0] c, input logic fresh, input logic typed,
                             input logic [31:0] t_addr, input logic t_bad);
        logic [31:0] p_addr;
        logic        p_bad;
        bit          ends;
        verdict_t    v;
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tuser <= fresh;
        do
            @(posedge clk);
        while (!s_tready);
        ends = parse_char(c, fresh, p_addr, p_bad);
        if (typed)
        begin
            v.addr = t_addr;
            v.bad = t_bad;
            pending_verdicts.push_back(v);
        end
        else if (ends)
        begin
            v.addr = p_addr;
            v.bad = p_bad;
            pending_verdicts.push_back(v);
        end
        sent_chars++;
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    function automatic logic [7:0] digit_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10)
            return CH_ZERO + {4'd0, v};
        return (upper ? CH_UC_A : CH_LC_A) + {4'd0, v} - 8'd10;
    endfunction

    // One random address string, mostly well formed, or a burst of noise.
    task automatic send_random_text();
        logic [7:0] txt [$];
        int         kind;
        int         parts;
        int         form;
        int         len;
        int         pick;
        case ($urandom_range(0, 3))
            0:       gap_pct = 0;
            1:       gap_pct = 5;
            2:       gap_pct = 20;
            default: gap_pct = 50;
        endcase
        kind = $urandom_range(0, 99);
        if (kind < 82)
        begin
            // Five parts give the fourth dot error.
            parts = ($urandom_range(0, 19) == 0) ? 5 : $urandom_range(1, 4);
            for (int p = 0; p < parts; p++)
            begin
                if (p != 0)
                    txt.push_back(CH_DOT);
                form = $urandom_range(0, 9);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12)
                                                  : $urandom_range(1, 3);
                if (form >= 1 && form <= 4)
                begin
                    repeat (len) txt.push_back(digit_char(4'($urandom_range(0, 9)), 1'b0));
                end
                else if (form == 5 || form == 6)
                begin
                    txt.push_back(CH_ZERO);
                    repeat (len - 1)
                        txt.push_back(digit_char(4'($urandom_range(0, 9)), 1'b0));
                end
                else if (form >= 7)
                begin
                    pick = $urandom_range(0, 3);
                    if (pick < 2)
                        txt.push_back(CH_ZERO);
                    txt.push_back(pick[0] ? CH_UC_X : CH_LC_X);
                    repeat ($urandom_range(0, 1) ? len : len - 1)
                        txt.push_back(digit_char(4'($urandom_range(0, 15)),
                                                 1'($urandom_range(0, 1))));
                end
            end
            if ($urandom_range(0, 6) != 0)
            begin
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    txt.push_back(CH_NUL);
                else if (pick <= 5)
                    txt.push_back(CH_TAB + pick[7:0] - 8'd1);
                else
                    txt.push_back(CH_SPACE);
            end
            else
                txt.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 11) == 0)
                txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(0, 255)));
            foreach (txt[i])
                send_char(txt[i], i == 0, 1'b0, '0, 1'b0);
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                          1'b0, '0, 1'b0);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        verdict_t want;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_verdicts.size() == 0)
                report_mismatch("unexpected word, address", m_tdata, 32'h0);
            else
            begin
                want = pending_verdicts.pop_front();
                if (m_tdata !== want.addr)
                    report_mismatch("address", m_tdata, want.addr);
                if (m_tuser !== want.bad)
                    report_mismatch("bad_format", {31'd0, m_tuser}, {31'd0, want.bad});
            end
        end
    end

    initial
    begin : downstream
        int stall_left = 0;
        int sink_pct = 10;
        int tick = 0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (tick % 64 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       sink_pct = 0;
                    1:       sink_pct = 3;
                    2:       sink_pct = 12;
                    default: sink_pct = 40;
                endcase
            end
            if (stall_left != 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    m_tready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 99) < sink_pct)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 17);
            end
        end
    end

    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("dotted_ipv4_address_parser: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 26; i++)
            send_char(PROBES[i].ch, PROBES[i].fresh, PROBES[i].typed,
                      PROBES[i].addr, PROBES[i].bad);

        while (sent_chars < CHAR_TARGET)
        begin
            // The tail of the run streams with no gaps on either side.
            quiet = (sent_chars > CHAR_TARGET - 100);
            send_random_text();
        end
        s_tvalid <= 1'b0;

        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("dotted_ipv4_address_parser: match");
        else
            $display("dotted_ipv4_address_parser: mismatch");
        $finish;
    end

endmodule
